// ----- design/bpte_pkg.sv -----
// Shared types and constants for the Bezier point and tangent evaluator.
`timescale 1ns / 1ps

package bpte_pkg;

   localparam int COORD_W         = 32;
   localparam int OUT_W           = 40;
   localparam int ACTION_W        = 3;
   localparam int T_FRAC_BITS_DEF = 16;
   localparam int NUM_REGS        = 8;
   localparam int CSR_AW          = 5;
   localparam int CSR_DW          = 32;
   localparam int NUM_AXES        = 2;
   localparam int NUM_PTS         = 4;

   // Two guard bits cover differences of coordinates and the final scaling.
   localparam int LANE_W0 = COORD_W + 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LINEAR      = 3'd0,
      ACT_QUAD_POINT  = 3'd1,
      ACT_QUAD_DERIV  = 3'd2,
      ACT_CUBIC_POINT = 3'd3,
      ACT_CUBIC_DERIV = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      REG_START_X = 3'd0,
      REG_START_Y = 3'd1,
      REG_CTRL1_X = 3'd2,
      REG_CTRL1_Y = 3'd3,
      REG_CTRL2_X = 3'd4,
      REG_CTRL2_Y = 3'd5,
      REG_END_X   = 3'd6,
      REG_END_Y   = 3'd7
   } reg_index_type;

   // What one level of cells does with each neighboring pair of points a, b.
   // LERP: a*T + (b-a)*t, DIFF: (b-a)*T, HOLD: a*T.
   typedef enum logic [1:0] {
      MODE_LERP = 2'd0,
      MODE_DIFF = 2'd1,
      MODE_HOLD = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      SCALE_ZERO  = 2'd0,
      SCALE_ONE   = 2'd1,
      SCALE_TWO   = 2'd2,
      SCALE_THREE = 2'd3
   } scale_type;

   // Control that rides along with a transaction; each level consumes cur and shifts.
   typedef struct packed {
      mode_type  cur;
      mode_type  nxt;
      mode_type  last;
      scale_type scale;
   } ctrl_type;

endpackage

// ----- design/bpte_if.sv -----
// Request and response channel interfaces of the Bezier evaluator.
`timescale 1ns / 1ps

interface bpte_req_if #(
   parameter int T_W = bpte_pkg::T_FRAC_BITS_DEF + 1
);
   logic                          valid;
   logic                          ready;
   logic [bpte_pkg::ACTION_W-1:0] action;
   logic [T_W-1:0]                t_param;

   modport source (output valid, output action, output t_param, input ready);
   modport sink (input valid, input action, input t_param, output ready);
endinterface

interface bpte_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [bpte_pkg::OUT_W-1:0] out_x;
   logic signed [bpte_pkg::OUT_W-1:0] out_y;

   modport source (output valid, output out_x, output out_y, input ready);
   modport sink (input valid, input out_x, input out_y, output ready);
endinterface

// ----- design/bpte_cell.sv -----
// One de Casteljau cell: combines two neighboring points and registers the result.
`timescale 1ns / 1ps

module bpte_cell #(
   parameter int IN_W        = bpte_pkg::LANE_W0,
   parameter int T_FRAC_BITS = bpte_pkg::T_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            load,
   input  logic signed [IN_W-1:0]          pt_a,
   input  logic signed [IN_W-1:0]          pt_b,
   input  logic                            keep_a,
   input  logic [T_FRAC_BITS:0]            weight,
   output logic signed [IN_W+T_FRAC_BITS-1:0] lane_ff
);

   localparam int RES_W  = IN_W + T_FRAC_BITS;
   localparam int PROD_W = IN_W + T_FRAC_BITS + 3;

   logic signed [IN_W:0]          diff;
   logic signed [T_FRAC_BITS+1:0] weight_s;
   logic signed [PROD_W-1:0]      prod;
   logic signed [RES_W-1:0]       base;
   logic signed [RES_W-1:0]       lane_in;

   // The true result always fits RES_W bits, so the wrap of the sum is exact.
   always_comb begin
      diff     = {pt_b[IN_W-1], pt_b} - {pt_a[IN_W-1], pt_a};
      weight_s = {1'b0, weight};
      prod     = PROD_W'(diff) * PROD_W'(weight_s);
      base     = keep_a ? {pt_a, {T_FRAC_BITS{1'b0}}} : '0;
      lane_in  = base + prod[RES_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lane_ff <= lane_in;
      end
   end

endmodule

// ----- design/bpte_level.sv -----
// One level of the de Casteljau chain: a row of cells for both axes plus its control stage.
`timescale 1ns / 1ps

module bpte_level #(
   parameter int PTS_IN      = bpte_pkg::NUM_PTS,
   parameter int IN_W        = bpte_pkg::LANE_W0,
   parameter int T_FRAC_BITS = bpte_pkg::T_FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  bpte_pkg::ctrl_type   in_ctrl,
   input  logic [T_FRAC_BITS:0] in_t,
   input  logic [bpte_pkg::NUM_AXES-1:0][PTS_IN-1:0][IN_W-1:0] in_pts,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bpte_pkg::ctrl_type   out_ctrl,
   output logic [T_FRAC_BITS:0] out_t,
   output logic [bpte_pkg::NUM_AXES-1:0][PTS_IN-2:0][IN_W+T_FRAC_BITS-1:0] out_pts
);

   localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

   logic                 valid_ff;
   logic                 valid_in;
   logic                 load;
   logic                 keep_a;
   logic [T_FRAC_BITS:0] weight;
   bpte_pkg::ctrl_type   ctrl_ff;
   bpte_pkg::ctrl_type   ctrl_in;
   logic [T_FRAC_BITS:0] t_ff;

   always_comb begin
      in_ready = !valid_ff || out_ready;
      load     = in_valid && in_ready;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
      ctrl_in.cur   = in_ctrl.nxt;
      ctrl_in.nxt   = in_ctrl.last;
      ctrl_in.last  = bpte_pkg::MODE_HOLD;
      ctrl_in.scale = in_ctrl.scale;
   end

   always_comb begin
      unique case (in_ctrl.cur)
         bpte_pkg::MODE_LERP: begin
            keep_a = 1'b1;
            weight = in_t;
         end
         bpte_pkg::MODE_DIFF: begin
            keep_a = 1'b0;
            weight = T_ONE;
         end
         bpte_pkg::MODE_HOLD: begin
            keep_a = 1'b1;
            weight = '0;
         end
         default: begin
            keep_a = 1'b1;
            weight = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ctrl_ff <= ctrl_in;
         t_ff    <= in_t;
      end
   end

   for (genvar ax = 0; ax < bpte_pkg::NUM_AXES; ax++) begin : g_axis
      for (genvar ln = 0; ln < PTS_IN - 1; ln++) begin : g_lane
         bpte_cell #(
            .IN_W        (IN_W),
            .T_FRAC_BITS (T_FRAC_BITS)
         ) u_cell (
            .clock   (clock),
            .load    (load),
            .pt_a    (in_pts[ax][ln]),
            .pt_b    (in_pts[ax][ln+1]),
            .keep_a  (keep_a),
            .weight  (weight),
            .lane_ff (out_pts[ax][ln])
         );
      end
   end

   assign out_valid = valid_ff;
   assign out_ctrl  = ctrl_ff;
   assign out_t     = t_ff;

endmodule

// ----- design/bpte_round.sv -----
// Output stage: applies the derivative factor, rounds to nearest and holds the result.
`timescale 1ns / 1ps

module bpte_round #(
   parameter int IN_W        = bpte_pkg::LANE_W0,
   parameter int T_FRAC_BITS = bpte_pkg::T_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  bpte_pkg::ctrl_type                in_ctrl,
   input  logic [bpte_pkg::NUM_AXES-1:0][IN_W-1:0] in_pts,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [bpte_pkg::OUT_W-1:0] out_x_ff,
   output logic signed [bpte_pkg::OUT_W-1:0] out_y_ff
);

   localparam int SCL_W = IN_W + 2;
   localparam int SHIFT = 3 * T_FRAC_BITS;
   localparam logic signed [SCL_W-1:0] HALF = SCL_W'(1) << (SHIFT - 1);

   logic                              valid_ff;
   logic                              valid_in;
   logic                              load;
   logic signed [SCL_W-1:0]           val    [bpte_pkg::NUM_AXES];
   logic signed [SCL_W-1:0]           scaled [bpte_pkg::NUM_AXES];
   logic signed [SCL_W-1:0]           biased [bpte_pkg::NUM_AXES];
   logic signed [SCL_W-1:0]           quot   [bpte_pkg::NUM_AXES];
   logic signed [bpte_pkg::OUT_W-1:0] res    [bpte_pkg::NUM_AXES];

   always_comb begin
      in_ready = !valid_ff || out_ready;
      load     = in_valid && in_ready;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   // Every lane arrives over the denominator T^3, so one shift rounds all actions.
   always_comb begin
      for (int ax = 0; ax < bpte_pkg::NUM_AXES; ax++) begin
         val[ax] = SCL_W'($signed(in_pts[ax]));
         unique case (in_ctrl.scale)
            bpte_pkg::SCALE_ZERO:  scaled[ax] = '0;
            bpte_pkg::SCALE_ONE:   scaled[ax] = val[ax];
            bpte_pkg::SCALE_TWO:   scaled[ax] = val[ax] <<< 1;
            bpte_pkg::SCALE_THREE: scaled[ax] = val[ax] + (val[ax] <<< 1);
         endcase
         biased[ax] = scaled[ax] + HALF;
         quot[ax]   = biased[ax] >>> SHIFT;
         res[ax]    = quot[ax][bpte_pkg::OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_x_ff <= res[0];
         out_y_ff <= res[1];
      end
   end

   assign out_valid = valid_ff;

endmodule

// ----- design/bezier_point_and_tangent_eval_top.sv -----
// Each transaction is registered by level 1, level 2, level 3, then the rounding stage.
// Throughput: one transaction per cycle while rsp_chan is ready; every stage holds one
// transaction, and a stage refills as soon as its neighbor takes its data.
// Reset clears every stage valid and sets all eight coordinate registers to zero.
// Points and derivatives are exact de Casteljau lerps and differences, rounded to nearest, ties up.
`timescale 1ns / 1ps

module bezier_point_and_tangent_eval_top #(
   parameter int T_FRAC_BITS = bpte_pkg::T_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   bpte_req_if.sink                      req_chan,
   bpte_rsp_if.source                    rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bpte_pkg::CSR_AW-1:0]   paddr,
   input  logic [bpte_pkg::CSR_DW-1:0]   pwdata,
   output logic [bpte_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);

   localparam int W0 = bpte_pkg::LANE_W0;
   localparam int W1 = W0 + T_FRAC_BITS;
   localparam int W2 = W1 + T_FRAC_BITS;
   localparam int W3 = W2 + T_FRAC_BITS;
   localparam int NA = bpte_pkg::NUM_AXES;
   localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

   logic [bpte_pkg::COORD_W-1:0] cfg_ff [bpte_pkg::NUM_REGS];
   logic                         csr_write;
   logic [2:0]                   csr_index;

   logic [bpte_pkg::ACTION_W-1:0] action;
   logic [T_FRAC_BITS:0]          t_raw;
   logic [T_FRAC_BITS:0]          t_sat;
   logic                          is_linear;
   logic                          is_cubic;
   bpte_pkg::ctrl_type            l0_ctrl;

   logic [NA-1:0][3:0][W0-1:0] l0_pts;
   logic [NA-1:0][2:0][W1-1:0] l1_pts;
   logic [NA-1:0][1:0][W2-1:0] l2_pts;
   logic [NA-1:0][0:0][W3-1:0] l3_pts;

   logic                 l1_valid, l2_valid, l3_valid;
   logic                 l1_ready, l2_ready, l3_ready, rnd_ready;
   bpte_pkg::ctrl_type   l1_ctrl, l2_ctrl, l3_ctrl;
   logic [T_FRAC_BITS:0] l1_t, l2_t;

   // Configuration port.
   always_comb begin
      csr_write = psel && penable && pwrite;
      csr_index = paddr[bpte_pkg::CSR_AW-1:2];
      prdata    = cfg_ff[csr_index];
      pready    = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bpte_pkg::NUM_REGS; i++) begin
            cfg_ff[i] <= '0;
         end
      end else if (csr_write) begin
         cfg_ff[csr_index] <= pwdata;
      end
   end

   // Front end: clamp t, pick the control points and the per-level cell modes.
   always_comb begin
      action    = req_chan.action;
      t_raw     = req_chan.t_param;
      t_sat     = (t_raw > T_ONE) ? T_ONE : t_raw;
      is_linear = (action == bpte_pkg::ACT_LINEAR);
      is_cubic  = (action == bpte_pkg::ACT_CUBIC_POINT) ||
                  (action == bpte_pkg::ACT_CUBIC_DERIV);

      l0_pts[0][0] = W0'($signed(cfg_ff[bpte_pkg::REG_START_X]));
      l0_pts[1][0] = W0'($signed(cfg_ff[bpte_pkg::REG_START_Y]));
      l0_pts[0][1] = is_linear ? W0'($signed(cfg_ff[bpte_pkg::REG_END_X]))
                               : W0'($signed(cfg_ff[bpte_pkg::REG_CTRL1_X]));
      l0_pts[1][1] = is_linear ? W0'($signed(cfg_ff[bpte_pkg::REG_END_Y]))
                               : W0'($signed(cfg_ff[bpte_pkg::REG_CTRL1_Y]));
      l0_pts[0][2] = is_cubic ? W0'($signed(cfg_ff[bpte_pkg::REG_CTRL2_X]))
                              : W0'($signed(cfg_ff[bpte_pkg::REG_END_X]));
      l0_pts[1][2] = is_cubic ? W0'($signed(cfg_ff[bpte_pkg::REG_CTRL2_Y]))
                              : W0'($signed(cfg_ff[bpte_pkg::REG_END_Y]));
      l0_pts[0][3] = W0'($signed(cfg_ff[bpte_pkg::REG_END_X]));
      l0_pts[1][3] = W0'($signed(cfg_ff[bpte_pkg::REG_END_Y]));

      // Lower-degree forms hold (multiply by one) in the remaining levels so that
      // every result leaves the chain over the same denominator.
      unique case (action)
         bpte_pkg::ACT_LINEAR: begin
            l0_ctrl = '{cur: bpte_pkg::MODE_LERP, nxt: bpte_pkg::MODE_HOLD,
                        last: bpte_pkg::MODE_HOLD, scale: bpte_pkg::SCALE_ONE};
         end
         bpte_pkg::ACT_QUAD_POINT: begin
            l0_ctrl = '{cur: bpte_pkg::MODE_LERP, nxt: bpte_pkg::MODE_LERP,
                        last: bpte_pkg::MODE_HOLD, scale: bpte_pkg::SCALE_ONE};
         end
         bpte_pkg::ACT_QUAD_DERIV: begin
            l0_ctrl = '{cur: bpte_pkg::MODE_LERP, nxt: bpte_pkg::MODE_DIFF,
                        last: bpte_pkg::MODE_HOLD, scale: bpte_pkg::SCALE_TWO};
         end
         bpte_pkg::ACT_CUBIC_POINT: begin
            l0_ctrl = '{cur: bpte_pkg::MODE_LERP, nxt: bpte_pkg::MODE_LERP,
                        last: bpte_pkg::MODE_LERP, scale: bpte_pkg::SCALE_ONE};
         end
         bpte_pkg::ACT_CUBIC_DERIV: begin
            l0_ctrl = '{cur: bpte_pkg::MODE_LERP, nxt: bpte_pkg::MODE_LERP,
                        last: bpte_pkg::MODE_DIFF, scale: bpte_pkg::SCALE_THREE};
         end
         default: begin
            // Unknown actions run through the chain and come out as zero.
            l0_ctrl = '{cur: bpte_pkg::MODE_HOLD, nxt: bpte_pkg::MODE_HOLD,
                        last: bpte_pkg::MODE_HOLD, scale: bpte_pkg::SCALE_ZERO};
         end
      endcase
   end

   assign req_chan.ready = l1_ready;

   bpte_level #(
      .PTS_IN      (4),
      .IN_W        (W0),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_level1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (l1_ready),
      .in_ctrl   (l0_ctrl),
      .in_t      (t_sat),
      .in_pts    (l0_pts),
      .out_valid (l1_valid),
      .out_ready (l2_ready),
      .out_ctrl  (l1_ctrl),
      .out_t     (l1_t),
      .out_pts   (l1_pts)
   );

   bpte_level #(
      .PTS_IN      (3),
      .IN_W        (W1),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_level2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (l1_valid),
      .in_ready  (l2_ready),
      .in_ctrl   (l1_ctrl),
      .in_t      (l1_t),
      .in_pts    (l1_pts),
      .out_valid (l2_valid),
      .out_ready (l3_ready),
      .out_ctrl  (l2_ctrl),
      .out_t     (l2_t),
      .out_pts   (l2_pts)
   );

   bpte_level #(
      .PTS_IN      (2),
      .IN_W        (W2),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_level3 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (l2_valid),
      .in_ready  (l3_ready),
      .in_ctrl   (l2_ctrl),
      .in_t      (l2_t),
      .in_pts    (l2_pts),
      .out_valid (l3_valid),
      .out_ready (rnd_ready),
      .out_ctrl  (l3_ctrl),
      .out_t     (),
      .out_pts   (l3_pts)
   );

   bpte_round #(
      .IN_W        (W3),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (l3_valid),
      .in_ready  (rnd_ready),
      .in_ctrl   (l3_ctrl),
      .in_pts    (l3_pts),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_x_ff  (rsp_chan.out_x),
      .out_y_ff  (rsp_chan.out_y)
   );

`ifndef ASSERT_OFF
   a_cfg_write_lands: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_index == bpte_pkg::REG_END_Y) |=>
         (cfg_ff[bpte_pkg::REG_END_Y] == $past(pwdata)))
      else $error("end_y register did not take the written value");

   a_unknown_action_zero: assert property (@(posedge clock) disable iff (reset)
      (l3_valid && rnd_ready && l3_ctrl.scale == bpte_pkg::SCALE_ZERO) |=>
         (rsp_chan.out_x == '0 && rsp_chan.out_y == '0))
      else $error("unknown action produced a nonzero result");

   a_stalled_level_keeps_item: assert property (@(posedge clock) disable iff (reset)
      (l2_valid && !l3_ready) |=> l2_valid)
      else $error("second level dropped a transaction while stalled");

   a_reset_empties_chain: assert property (@(posedge clock)
      (!reset && $past(reset)) |->
         (!rsp_chan.valid && !l1_valid && !l2_valid && !l3_valid))
      else $error("pipeline holds a transaction right after reset");
`endif

endmodule
